[hw/rtl/glyph_cache_shelf_allocator_core_defines.svh]
// assertion macros used by the checker file
`ifndef GLYPH_CACHE_SHELF_ALLOCATOR_CORE_DEFINES_SVH
`define GLYPH_CACHE_SHELF_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define GCSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define GCSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/gcsa_pkg.sv]
package gcsa_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int GLYPH_PAD   = 1;
    localparam int MAX_ATLAS   = 4096;

    localparam int IDX_W    = $clog2(MAX_ENTRIES);
    localparam int TOTAL_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ATLAS_W  = 13;
    localparam int CURSOR_W = 14;
    localparam int SUM_W    = CURSOR_W + 1;

    localparam logic [CURSOR_W-1:0] CURSOR_MAX = '1;
    localparam logic [ATLAS_W-1:0]  ATLAS_MAX  = ATLAS_W'(MAX_ATLAS);
    localparam logic [ATLAS_W-1:0]  ATLAS_RST  = ATLAS_W'(1024);
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = TOTAL_W'(MAX_ENTRIES);

    typedef logic [36:0] t_key;

    typedef struct packed {
        logic signed [15:0] adv;
        logic signed [15:0] by;
        logic signed [15:0] bx;
    } t_metric;

    typedef struct packed {
        logic [11:0] h;
        logic [11:0] w;
        logic [11:0] y;
        logic [11:0] x;
    } t_place;

    typedef struct packed {
        t_place  place;
        t_metric metric;
        t_key    key;
    } t_entry;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
    } t_mem_req;

    typedef enum logic [2:0] {
        ST_HIT         = 3'd0,
        ST_PLACED      = 3'd1,
        ST_BLANK       = 3'd2,
        ST_TABLE_FULL  = 3'd3,
        ST_ATLAS_FULL  = 3'd4
    } t_status;

    typedef enum logic {
        CFG_ATLAS_WIDTH  = 1'b0,
        CFG_ATLAS_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_MISS,
        S_PACK_X,
        S_NEW_SHELF,
        S_PACK_Y,
        S_COMMIT,
        S_RESP
    } t_state;

    typedef struct packed {
        t_status     status;
        logic [7:0]  idx;
        t_place      place;
        t_metric     metric;
    } t_result;

endpackage

[hw/rtl/gcsa_store.sv]
module gcsa_store (
    input  logic                              i_clk,
    input  gcsa_pkg::t_mem_req                i_req,
    input  gcsa_pkg::t_entry                  i_wr_data,
    output gcsa_pkg::t_entry                  o_rd_data
);

    gcsa_pkg::t_entry r_mem [gcsa_pkg::MAX_ENTRIES];
    gcsa_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/glyph_cache_shelf_allocator_core.sv]
// a hit returns the stored entry as soon as the key scan finds it; a miss scans
// every entry, then runs the shelf packer unless the table is full or the glyph is blank
// throughput: one request at a time, the next one is taken the cycle after the
// result is moved to the output register; the one-entry-per-cycle key scan sets it
// reset (synchronous, active low) clears the entry count, the shelf cursors and
// sets both atlas registers to 1024; the entry memory is not cleared
module glyph_cache_shelf_allocator_core (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [12:0]        i_cfg_data,

    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_face_id,
    input  logic [20:0]        i_glyph_key,
    input  logic [7:0]         i_size_px,
    input  logic [11:0]        i_glyph_width,
    input  logic [11:0]        i_glyph_height,
    input  logic signed [15:0] i_origin_x,
    input  logic signed [15:0] i_origin_y,
    input  logic signed [15:0] i_advance_x,

    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic [7:0]         o_entry_index,
    output logic [11:0]        o_place_x,
    output logic [11:0]        o_place_y,
    output logic [11:0]        o_placed_width,
    output logic [11:0]        o_placed_height,
    output logic signed [15:0] o_entry_origin_x,
    output logic signed [15:0] o_entry_origin_y,
    output logic signed [15:0] o_entry_advance
);

    // control state
    gcsa_pkg::t_state                      r_state, n_state;
    logic [gcsa_pkg::ATLAS_W-1:0]          r_atlas_w, r_atlas_h;
    logic [gcsa_pkg::TOTAL_W-1:0]          r_total, n_total;
    logic [gcsa_pkg::TOTAL_W-1:0]          r_addr, n_addr;
    logic [gcsa_pkg::IDX_W-1:0]            r_cmp_idx, n_cmp_idx;
    logic                                  r_cmp_vld, n_cmp_vld;
    logic [gcsa_pkg::CURSOR_W-1:0]         r_cx, n_cx, r_cy, n_cy;
    logic [gcsa_pkg::ATLAS_W-1:0]          r_tall, n_tall;
    logic                                  r_out_vld, n_out_vld;

    // payload
    gcsa_pkg::t_key                        r_key;
    gcsa_pkg::t_metric                     r_metric;
    logic [11:0]                           r_w, r_h;
    logic [gcsa_pkg::ATLAS_W-1:0]          r_pw, r_ph;
    gcsa_pkg::t_result                     r_res, n_res;
    gcsa_pkg::t_result                     r_out, n_out;

    // store port
    gcsa_pkg::t_mem_req                    mem_req;
    gcsa_pkg::t_entry                      wr_data;
    gcsa_pkg::t_entry                      rd_data;

    // shared adder and compare
    logic [gcsa_pkg::CURSOR_W-1:0]         add_a;
    logic [gcsa_pkg::ATLAS_W-1:0]          add_b;
    logic [gcsa_pkg::ATLAS_W-1:0]          lim;
    logic [gcsa_pkg::SUM_W-1:0]            sum;
    logic [gcsa_pkg::CURSOR_W-1:0]         sum_sat;
    logic                                  over;

    logic [gcsa_pkg::ATLAS_W-1:0]          aw_eff, ah_eff;
    logic                                  in_xfer, hit, more, full, blank, out_free;

    gcsa_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    assign aw_eff = (r_atlas_w > gcsa_pkg::ATLAS_MAX) ? gcsa_pkg::ATLAS_MAX : r_atlas_w;
    assign ah_eff = (r_atlas_h > gcsa_pkg::ATLAS_MAX) ? gcsa_pkg::ATLAS_MAX : r_atlas_h;

    assign o_stall  = (r_state != gcsa_pkg::S_IDLE);
    assign in_xfer  = i_valid && !o_stall;
    assign hit      = r_cmp_vld && (rd_data.key == r_key);
    assign more     = (r_addr < r_total);
    assign full     = (r_total >= gcsa_pkg::TOTAL_MAX);
    assign blank    = (r_w == 12'd0) || (r_h == 12'd0);
    assign out_free = !r_out_vld || !i_stall;

    // operand select for the shared adder
    always_comb begin
        add_a = r_cx;
        add_b = r_pw;
        lim   = aw_eff;
        unique case (r_state)
            gcsa_pkg::S_NEW_SHELF: begin
                add_a = r_cy;
                add_b = r_tall;
            end
            gcsa_pkg::S_PACK_Y: begin
                add_a = r_cy;
                add_b = r_ph;
                lim   = ah_eff;
            end
            default: begin
                add_a = r_cx;
                add_b = r_pw;
                lim   = aw_eff;
            end
        endcase
    end

    assign sum     = gcsa_pkg::SUM_W'(add_a) + gcsa_pkg::SUM_W'(add_b);
    assign over    = (sum > gcsa_pkg::SUM_W'(lim));
    assign sum_sat = (sum > gcsa_pkg::SUM_W'(gcsa_pkg::CURSOR_MAX)) ?
                     gcsa_pkg::CURSOR_MAX : sum[gcsa_pkg::CURSOR_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gcsa_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = gcsa_pkg::S_SEARCH;
                end
            end
            gcsa_pkg::S_SEARCH: begin
                if (hit) begin
                    n_state = gcsa_pkg::S_RESP;
                end else if (!more) begin
                    n_state = gcsa_pkg::S_MISS;
                end
            end
            gcsa_pkg::S_MISS: begin
                if (full || blank) begin
                    n_state = gcsa_pkg::S_RESP;
                end else begin
                    n_state = gcsa_pkg::S_PACK_X;
                end
            end
            gcsa_pkg::S_PACK_X: begin
                n_state = over ? gcsa_pkg::S_NEW_SHELF : gcsa_pkg::S_PACK_Y;
            end
            gcsa_pkg::S_NEW_SHELF: begin
                n_state = gcsa_pkg::S_PACK_Y;
            end
            gcsa_pkg::S_PACK_Y: begin
                n_state = over ? gcsa_pkg::S_RESP : gcsa_pkg::S_COMMIT;
            end
            gcsa_pkg::S_COMMIT: begin
                n_state = gcsa_pkg::S_RESP;
            end
            gcsa_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = gcsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gcsa_pkg::S_IDLE;
            end
        endcase
    end

    // datapath controls and next values
    always_comb begin
        n_total   = r_total;
        n_addr    = r_addr;
        n_cmp_idx = r_cmp_idx;
        n_cmp_vld = r_cmp_vld;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_tall    = r_tall;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld && i_stall;

        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = r_addr[gcsa_pkg::IDX_W-1:0];
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = r_total[gcsa_pkg::IDX_W-1:0];

        wr_data.key          = r_key;
        wr_data.metric       = r_metric;
        wr_data.place.x      = r_cx[11:0];
        wr_data.place.y      = r_cy[11:0];
        wr_data.place.w      = r_w;
        wr_data.place.h      = r_h;

        unique case (r_state)
            gcsa_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_addr    = '0;
                    n_cmp_vld = 1'b0;
                end
            end
            gcsa_pkg::S_SEARCH: begin
                // compare the entry read last cycle while the next one is fetched
                if (hit) begin
                    n_res.status = gcsa_pkg::ST_HIT;
                    n_res.idx    = 8'(r_cmp_idx);
                    n_res.place  = rd_data.place;
                    n_res.metric = rd_data.metric;
                end else if (more) begin
                    mem_req.rd_en = 1'b1;
                    n_cmp_idx     = r_addr[gcsa_pkg::IDX_W-1:0];
                    n_cmp_vld     = 1'b1;
                    n_addr        = r_addr + gcsa_pkg::TOTAL_W'(1);
                end else begin
                    n_cmp_vld = 1'b0;
                end
            end
            gcsa_pkg::S_MISS: begin
                if (full) begin
                    n_res        = '0;
                    n_res.status = gcsa_pkg::ST_TABLE_FULL;
                end else if (blank) begin
                    wr_data.place = '0;
                    mem_req.wr_en = 1'b1;
                    n_total       = r_total + gcsa_pkg::TOTAL_W'(1);
                    n_res.status  = gcsa_pkg::ST_BLANK;
                    n_res.idx     = 8'(r_total);
                    n_res.place   = '0;
                    n_res.metric  = r_metric;
                end
            end
            gcsa_pkg::S_NEW_SHELF: begin
                n_cx   = '0;
                n_cy   = sum_sat;
                n_tall = '0;
            end
            gcsa_pkg::S_PACK_Y: begin
                // the shelf move made above is kept on failure
                if (over) begin
                    n_res        = '0;
                    n_res.status = gcsa_pkg::ST_ATLAS_FULL;
                end
            end
            gcsa_pkg::S_COMMIT: begin
                mem_req.wr_en = 1'b1;
                n_total       = r_total + gcsa_pkg::TOTAL_W'(1);
                n_cx          = sum_sat;
                if (r_ph > r_tall) begin
                    n_tall = r_ph;
                end
                n_res.status  = gcsa_pkg::ST_PLACED;
                n_res.idx     = 8'(r_total);
                n_res.place   = wr_data.place;
                n_res.metric  = r_metric;
            end
            gcsa_pkg::S_RESP: begin
                if (out_free) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                end
            end
            default: begin
                n_cmp_vld = r_cmp_vld;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gcsa_pkg::S_IDLE;
            r_atlas_w <= gcsa_pkg::ATLAS_RST;
            r_atlas_h <= gcsa_pkg::ATLAS_RST;
            r_total   <= '0;
            r_addr    <= '0;
            r_cmp_idx <= '0;
            r_cmp_vld <= 1'b0;
            r_cx      <= '0;
            r_cy      <= '0;
            r_tall    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_addr    <= n_addr;
            r_cmp_idx <= n_cmp_idx;
            r_cmp_vld <= n_cmp_vld;
            r_cx      <= n_cx;
            r_cy      <= n_cy;
            r_tall    <= n_tall;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                unique case (gcsa_pkg::t_cfg_idx'(i_cfg_idx))
                    gcsa_pkg::CFG_ATLAS_WIDTH:  r_atlas_w <= i_cfg_data;
                    gcsa_pkg::CFG_ATLAS_HEIGHT: r_atlas_h <= i_cfg_data;
                    default:                    r_atlas_w <= r_atlas_w;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_key      <= {i_size_px, i_glyph_key, i_face_id};
            r_metric   <= {i_advance_x, i_origin_y, i_origin_x};
            r_w        <= i_glyph_width;
            r_h        <= i_glyph_height;
            r_pw       <= gcsa_pkg::ATLAS_W'(i_glyph_width) +
                          gcsa_pkg::ATLAS_W'(gcsa_pkg::GLYPH_PAD);
            r_ph       <= gcsa_pkg::ATLAS_W'(i_glyph_height) +
                          gcsa_pkg::ATLAS_W'(gcsa_pkg::GLYPH_PAD);
        end
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_valid           = r_out_vld;
    assign o_status          = r_out.status;
    assign o_entry_index     = r_out.idx;
    assign o_place_x         = r_out.place.x;
    assign o_place_y         = r_out.place.y;
    assign o_placed_width    = r_out.place.w;
    assign o_placed_height   = r_out.place.h;
    assign o_entry_origin_x  = r_out.metric.bx;
    assign o_entry_origin_y  = r_out.metric.by;
    assign o_entry_advance   = r_out.metric.adv;

endmodule

[hw/rtl/gcsa_checker.sv]
`include "glyph_cache_shelf_allocator_core_defines.svh"

module gcsa_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [2:0]  o_status,
    input  logic [7:0]  o_entry_index,
    input  logic [11:0] o_place_x,
    input  logic [11:0] o_place_y,
    input  logic [11:0] o_placed_width,
    input  logic [11:0] o_placed_height
);

    // one request at a time: busy right after an input transfer
    `GCSA_ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "not busy after input transfer")

    `GCSA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped while stalled")

    // failed lookups carry no entry
    `GCSA_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_valid && (o_status == gcsa_pkg::ST_TABLE_FULL || o_status == gcsa_pkg::ST_ATLAS_FULL), o_entry_index == 8'd0 && o_place_x == 12'd0 && o_place_y == 12'd0 && o_placed_width == 12'd0 && o_placed_height == 12'd0, "failure result not cleared")

    `GCSA_ASSERT_NOW(a_blank_shape, i_clk, i_rst_n, o_valid && o_status == gcsa_pkg::ST_BLANK, o_place_x == 12'd0 && o_place_y == 12'd0 && (o_placed_width == 12'd0 || o_placed_height == 12'd0), "blank glyph with placement")

endmodule

bind glyph_cache_shelf_allocator_core gcsa_checker u_gcsa_checker (.*);
